FILE: rtl/core/htg_pkg.sv
package htg_pkg;

    localparam int ID_W   = 16;
    localparam int POS_W  = 6;
    localparam int CHAN_W = 7;
    localparam int BAND_W = 5;

    // Full generator constants; only the low 16 bits survive the mod 2^16.
    localparam logic [31:0] LCG_MUL = 32'h0019660D;
    localparam logic [31:0] LCG_ADD = 32'h3C6EF35F;

    localparam logic [7:0]        CHAN_SPAN  = 8'h4B;
    localparam logic [CHAN_W-1:0] MID_START  = 7'd27;
    localparam logic [CHAN_W-1:0] HIGH_START = 7'd53;
    localparam logic [BAND_W-1:0] EDGE_QUOTA = 5'd16;
    localparam logic [BAND_W-1:0] MID_QUOTA  = 5'd15;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DRAW    = 7'b0000010,
        ST_CHAN    = 7'b0000100,
        ST_SCAN    = 7'b0001000,
        ST_DECIDE  = 7'b0010000,
        ST_EMIT_RD = 7'b0100000,
        ST_EMIT_LD = 7'b1000000
    } state_t;

    typedef struct packed {
        logic            load;
        logic            step;
        logic [ID_W-1:0] seed;
    } draw_ctrl_t;

endpackage

FILE: rtl/core/htg_ram.sv
module htg_ram
    import htg_pkg::*;
#(
    parameter int DEPTH = 47,
    parameter int AW    = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CHAN_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [CHAN_W-1:0] rd_data
);

    logic [CHAN_W-1:0] mem [DEPTH];
    logic [CHAN_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/htg_draw.sv
module htg_draw
    import htg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  draw_ctrl_t        ctrl,
    output logic [CHAN_W-1:0] chan
);

    logic [ID_W-1:0]   lcg_reg;
    logic [ID_W-1:0]   lcg_next;
    logic [ID_W-1:0]   prod;
    logic [7:0]        hi;
    logic [7:0]        rem;

    // low half of the product is all that matters mod 2^16
    assign prod = lcg_reg * LCG_MUL[ID_W-1:0];

    always_comb begin
        lcg_next = lcg_reg;
        if (ctrl.load) begin
            lcg_next = ~ctrl.seed;
        end else if (ctrl.step) begin
            lcg_next = prod + LCG_ADD[ID_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_reg <= '0;
        end else begin
            lcg_reg <= lcg_next;
        end
    end

    // (state >> 8) mod 75: at most three spans fit in 8 bits
    assign hi = lcg_reg[ID_W-1:8];

    always_comb begin
        if (hi >= 8'(3 * CHAN_SPAN)) begin
            rem = hi - 8'(3 * CHAN_SPAN);
        end else if (hi >= 8'(2 * CHAN_SPAN)) begin
            rem = hi - 8'(2 * CHAN_SPAN);
        end else if (hi >= CHAN_SPAN) begin
            rem = hi - CHAN_SPAN;
        end else begin
            rem = hi;
        end
    end

    assign chan = rem[CHAN_W-1:0] + 7'd1;

endmodule

FILE: rtl/core/hop_table_generator.sv
// Hop list generator. Each accepted word on s_ carries a transmitter id; the
// block answers on m_ with the hop list for that id: one word per entry
// (position 0..HOP_COUNT-1, channel 1..75), then a closing word with channel 0
// and last set (position HOP_COUNT on success; on hitting MAX_ATTEMPTS draws,
// position = entries found and failed set, after only those entries).
// Channels come from a 16-bit LCG seeded with ~id, mapped to ((s>>8)%75)+1,
// and are rejected if already listed, closer than MIN_SPACING to the previous
// entry, or if their band quota (1-26:16, 27-52:15, 53-75:16) is full.
// Timing: one id at a time. A draw passes through draw, channel map, one
// hop-table memory read per listed entry and decide; a draw with an empty
// list skips the reads. Output passes each word through a read state and a
// load state, bound by the single memory read port, and waits out any m_ready
// stall. s_ready rises when the closing word is loaded into the output
// register, so a new id can start while that word still waits.
module hop_table_generator
    import htg_pkg::*;
#(
    parameter int HOP_COUNT    = 47,
    parameter int MIN_SPACING  = 5,
    parameter int MAX_ATTEMPTS = 65536
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ID_W-1:0]   s_transmitter_id,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [POS_W-1:0]  m_position,
    output logic [CHAN_W-1:0] m_channel,
    output logic              m_last,
    output logic              m_failed
);

    localparam int AW    = (HOP_COUNT > 1) ? $clog2(HOP_COUNT) : 1;
    localparam int ATT_W = $clog2(MAX_ATTEMPTS + 1);

    state_t state_reg, state_next;

    logic [POS_W-1:0]  filled_reg, filled_next;
    logic [POS_W-1:0]  idx_reg, idx_next;       // scan index, then output index
    logic [BAND_W-1:0] low_reg, low_next;
    logic [BAND_W-1:0] mid_reg, mid_next;
    logic [BAND_W-1:0] high_reg, high_next;
    logic [ATT_W-1:0]  att_reg, att_next;
    logic              fail_reg, fail_next;
    logic [CHAN_W-1:0] ch_reg, ch_next;
    logic [CHAN_W-1:0] prev_reg, prev_next;

    logic              m_valid_reg, m_valid_next;
    logic [POS_W-1:0]  m_pos_reg, m_pos_next;
    logic [CHAN_W-1:0] m_chan_reg, m_chan_next;
    logic              m_last_reg, m_last_next;
    logic              m_fail_reg, m_fail_next;

    draw_ctrl_t        draw_ctrl;
    logic [CHAN_W-1:0] draw_chan;

    logic              wr_en;
    logic              rd_en;
    logic [POS_W-1:0]  rd_addr;
    logic [CHAN_W-1:0] rd_data;

    logic              s_fire;
    logic              out_free;
    logic [CHAN_W-1:0] diff;
    logic              too_close;

    htg_draw u_draw (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (draw_ctrl),
        .chan    (draw_chan)
    );

    htg_ram #(
        .DEPTH (HOP_COUNT),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (filled_reg[AW-1:0]),
        .wr_data (ch_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr[AW-1:0]),
        .rd_data (rd_data)
    );

    assign s_ready  = state_reg == ST_IDLE;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign diff      = (ch_reg > prev_reg) ? (ch_reg - prev_reg) : (prev_reg - ch_reg);
    assign too_close = (filled_reg != '0) && (diff < CHAN_W'(MIN_SPACING));

    always_comb begin
        state_next   = state_reg;
        filled_next  = filled_reg;
        idx_next     = idx_reg;
        low_next     = low_reg;
        mid_next     = mid_reg;
        high_next    = high_reg;
        att_next     = att_reg;
        fail_next    = fail_reg;
        ch_next      = ch_reg;
        prev_next    = prev_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_pos_next   = m_pos_reg;
        m_chan_next  = m_chan_reg;
        m_last_next  = m_last_reg;
        m_fail_next  = m_fail_reg;
        draw_ctrl    = '{load: 1'b0, step: 1'b0, seed: s_transmitter_id};
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    draw_ctrl.load = 1'b1;
                    filled_next    = '0;
                    low_next       = '0;
                    mid_next       = '0;
                    high_next      = '0;
                    att_next       = '0;
                    fail_next      = 1'b0;
                    state_next     = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (filled_reg == POS_W'(HOP_COUNT)) begin
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end else if (att_reg >= ATT_W'(MAX_ATTEMPTS)) begin
                    fail_next  = 1'b1;
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    att_next       = att_reg + 1'b1;
                    draw_ctrl.step = 1'b1;
                    state_next     = ST_CHAN;
                end
            end
            ST_CHAN: begin
                ch_next = draw_chan;
                if (filled_reg == '0) begin
                    state_next = ST_DECIDE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // rd_data holds entry idx_reg
                if (rd_data == ch_reg) begin
                    state_next = ST_DRAW;
                end else if (idx_reg == filled_reg - 1'b1) begin
                    state_next = ST_DECIDE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DECIDE: begin
                state_next = ST_DRAW;
                if (!too_close) begin
                    if (ch_reg < MID_START) begin
                        if (low_reg < EDGE_QUOTA) begin
                            low_next = low_reg + 1'b1;
                            wr_en    = 1'b1;
                        end
                    end else if (ch_reg < HIGH_START) begin
                        if (mid_reg < MID_QUOTA) begin
                            mid_next = mid_reg + 1'b1;
                            wr_en    = 1'b1;
                        end
                    end else begin
                        if (high_reg < EDGE_QUOTA) begin
                            high_next = high_reg + 1'b1;
                            wr_en     = 1'b1;
                        end
                    end
                end
                if (wr_en) begin
                    filled_next = filled_reg + 1'b1;
                    prev_next   = ch_reg;
                end
            end
            ST_EMIT_RD: begin
                if (idx_reg < filled_reg) begin
                    rd_en = 1'b1;
                end
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (idx_reg < filled_reg) begin
                        m_pos_next  = idx_reg;
                        m_chan_next = rd_data;
                        m_last_next = 1'b0;
                        m_fail_next = 1'b0;
                        idx_next    = idx_reg + 1'b1;
                        state_next  = ST_EMIT_RD;
                    end else begin
                        // closing word: bind slot or failure marker
                        m_pos_next  = filled_reg;
                        m_chan_next = '0;
                        m_last_next = 1'b1;
                        m_fail_next = fail_reg;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            filled_reg  <= '0;
            idx_reg     <= '0;
            low_reg     <= '0;
            mid_reg     <= '0;
            high_reg    <= '0;
            att_reg     <= '0;
            fail_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            filled_reg  <= filled_next;
            idx_reg     <= idx_next;
            low_reg     <= low_next;
            mid_reg     <= mid_next;
            high_reg    <= high_next;
            att_reg     <= att_next;
            fail_reg    <= fail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg     <= ch_next;
        prev_reg   <= prev_next;
        m_pos_reg  <= m_pos_next;
        m_chan_reg <= m_chan_next;
        m_last_reg <= m_last_next;
        m_fail_reg <= m_fail_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_position = m_pos_reg;
    assign m_channel  = m_chan_reg;
    assign m_last     = m_last_reg;
    assign m_failed   = m_fail_reg;

endmodule

FILE: sim/hop_table_generator_test.sv
module hop_table_generator_test;
    import htg_pkg::*;

    // The block is built with the default list shape and a reduced attempt cap.
    // A list that deadlocks (the band or spacing rules leave no legal channel)
    // then fails at the reduced cap rather than the default one. The cap is still
    // far above what a normal list needs, so the failure path stays a corner.
    localparam int HOP_COUNT    = 47;
    localparam int MIN_SPACING  = 5;
    localparam int MAX_ATTEMPTS = 1024;

    localparam int N_DIRECTED  = 14;
    localparam int N_RANDOM    = 125;
    localparam int HOLD_CYCLES = 6000;
    localparam int DRAIN       = 2 * (HOP_COUNT + 1) + 16;

    // Slowest legal id: every draw with a full scan, then 48 words, each held
    // by the longest stall burst. Taken four times over, plus the long hold.
    localparam longint WORST_ITEM = longint'(MAX_ATTEMPTS) * (HOP_COUNT + 2)
                                    + (HOP_COUNT + 1) * 16 + 16;
    localparam longint LIMIT = 4 * ((N_DIRECTED + 1 + N_RANDOM) * WORST_ITEM
                                    + HOLD_CYCLES);

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [CHAN_W-1:0] channel;
        logic              last;
        logic              failed;
    } hop_word_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [ID_W-1:0]   s_transmitter_id;
    logic              m_valid;
    logic              m_ready;
    logic [POS_W-1:0]  m_position;
    logic [CHAN_W-1:0] m_channel;
    logic              m_last;
    logic              m_failed;

    hop_table_generator #(
        .HOP_COUNT    (HOP_COUNT),
        .MIN_SPACING  (MIN_SPACING),
        .MAX_ATTEMPTS (MAX_ATTEMPTS)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_transmitter_id (s_transmitter_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position       (m_position),
        .m_channel        (m_channel),
        .m_last           (m_last),
        .m_failed         (m_failed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Words still owed by the block, oldest first.
    hop_word_t         pending_hops [$];
    int unsigned       mismatch_count = 0;

    // Random idling on both sides; the long receiver hold is asked by the
    // stimulus process and counted out by the receiver process.
    bit                idling_on = 1'b0;
    bit                hold_req = 1'b0;

    // Last computed list: channels, length, and whether the cap was hit.
    logic [CHAN_W-1:0] plan_chan [0:HOP_COUNT-1];
    int                plan_len;
    bit                plan_failed;

    // Edge ids, alternating bits, a back-to-back repeat and a neighbor.
    // No list can be read off by eye, so every row goes through the predictor.
    logic [ID_W-1:0]   directed_ids [0:N_DIRECTED-1] = '{
        16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h7FFF, 16'h8000, 16'h5555,
        16'hAAAA, 16'h00FF, 16'hFF00, 16'h1234, 16'h1234, 16'h1235, 16'hC3A5
    };

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Rejection sampler: 16-bit LCG seeded with ~id, one channel per draw,
    // kept only if new, far enough from the previous entry, and its band
    // still has room.
    function automatic void plan_hop_list(input logic [ID_W-1:0] id);
        logic [15:0]       seed;
        logic [31:0]       mix;
        logic [CHAN_W-1:0] cand;
        logic [CHAN_W-1:0] prev;
        logic [CHAN_W-1:0] spread;
        int                low_n;
        int                mid_n;
        int                high_n;
        int                tries;
        bit                reject;
        seed        = ~id;
        plan_len    = 0;
        plan_failed = 1'b0;
        low_n       = 0;
        mid_n       = 0;
        high_n      = 0;
        tries       = 0;
        while (plan_len < HOP_COUNT) begin
            if (tries >= MAX_ATTEMPTS) begin
                plan_failed = 1'b1;
                break;
            end
            tries++;
            mix  = {16'd0, seed} * LCG_MUL + LCG_ADD;
            seed = mix[15:0];
            cand = CHAN_W'(int'(seed[15:8]) % int'(CHAN_SPAN) + 1);

            reject = 1'b0;
            for (int k = 0; k < plan_len; k++)
                if (plan_chan[k] == cand)
                    reject = 1'b1;
            // no spacing rule on the first entry
            if (!reject && plan_len > 0) begin
                prev   = plan_chan[plan_len-1];
                spread = (cand > prev) ? cand - prev : prev - cand;
                if (spread < MIN_SPACING)
                    reject = 1'b1;
            end
            if (!reject) begin
                if (cand < MID_START) begin
                    if (low_n >= EDGE_QUOTA) reject = 1'b1;
                    else low_n++;
                end else if (cand < HIGH_START) begin
                    if (mid_n >= MID_QUOTA) reject = 1'b1;
                    else mid_n++;
                end else begin
                    if (high_n >= EDGE_QUOTA) reject = 1'b1;
                    else high_n++;
                end
            end
            if (!reject) begin
                plan_chan[plan_len] = cand;
                plan_len++;
            end
        end
    endfunction

    // Entries in order, then the closing word: channel 0, last set, position
    // equal to the entries found (the bind slot on success).
    function automatic void queue_hop_list(input logic [ID_W-1:0] id);
        hop_word_t word;
        plan_hop_list(id);
        for (int k = 0; k < plan_len; k++) begin
            word.position = POS_W'(k);
            word.channel  = plan_chan[k];
            word.last     = 1'b0;
            word.failed   = 1'b0;
            pending_hops.push_back(word);
        end
        word.position = POS_W'(plan_len);
        word.channel  = '0;
        word.last     = 1'b1;
        word.failed   = plan_failed;
        pending_hops.push_back(word);
    endfunction

    // Sampled on the rising edge; all inputs move on the falling edge.
    always @(posedge aclk) begin
        hop_word_t got;
        hop_word_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_position, m_channel, m_last, m_failed};
            if (pending_hops.size() == 0) begin
                report_mismatch($sformatf("unexpected word pos=%0d ch=%0d last=%0b fail=%0b",
                                          m_position, m_channel, m_last, m_failed));
            end else begin
                want = pending_hops.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "pos %0d/%0d ch %0d/%0d last %0b/%0b fail %0b/%0b (got/want)",
                        got.position, want.position, got.channel, want.channel,
                        got.last, want.last, got.failed, want.failed));
            end
        end
        if (aresetn && s_valid && s_ready)
            queue_hop_list(s_transmitter_id);
    end

    // Receiver: random stall bursts while idling is on, plus one long hold
    // that lets the block finish a list and back up behind the output word.
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        m_ready    = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 13);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the word
    // was taken, with s_valid still high so a gapless next word follows.
    task automatic offer_transmitter_id(input logic [ID_W-1:0] id);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_transmitter_id <= id;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        repeat (LIMIT) @(posedge aclk);
        $display("hop_table_generator verification failed");
        $finish;
    end

    initial begin
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] prev_id;
        int              cap_id;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_transmitter_id = '0;
        prev_id          = '0;

        // Look for an id whose list deadlocks, to drive the attempt cap.
        cap_id = -1;
        for (int k = 0; k < 1024 && cap_id < 0; k++) begin
            plan_hop_list(ID_W'(k));
            if (plan_failed)
                cap_id = k;
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        idling_on = 1'b1;
        for (int k = 0; k < N_DIRECTED; k++)
            offer_transmitter_id(directed_ids[k]);
        if (cap_id >= 0)
            offer_transmitter_id(ID_W'(cap_id));

        for (int n = 0; n < N_RANDOM; n++) begin
            // quiet stretch in the middle, and none at all near the end
            idling_on = (n < N_RANDOM - 20) && !(n >= 70 && n < 90);
            if (n == 30)
                hold_req = 1'b1;
            if (n == 50) begin
                // sender pause: nothing offered until the block has drained
                s_valid <= 1'b0;
                wait (pending_hops.size() == 0);
                @(negedge aclk);
            end
            case ($urandom_range(0, 9))
                0: id = prev_id;
                1: id = prev_id + 1'b1;
                2: begin
                    id = 16'h0001 << $urandom_range(0, 15);
                    if ($urandom_range(0, 1))
                        id = ~id;
                end
                default: id = ID_W'($urandom_range(0, 65535));
            endcase
            offer_transmitter_id(id);
            prev_id = id;
        end
        s_valid <= 1'b0;

        wait (pending_hops.size() == 0);
        repeat (DRAIN) @(posedge aclk);
        if (mismatch_count == 0 && pending_hops.size() == 0) begin
            $display("hop_table_generator verification clean");
        end else begin
            $display("hop_table_generator verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/htg_pkg.sv
rtl/core/htg_ram.sv
rtl/core/htg_draw.sv
rtl/core/hop_table_generator.sv
sim/hop_table_generator_test.sv
